/* rtl/framebuffer_fill_scroll_engine_top_assert.svh */
// Assertion macros used by the checker file of the framebuffer engine.
`ifndef FRAMEBUFFER_FILL_SCROLL_ENGINE_TOP_ASSERT_SVH
`define FRAMEBUFFER_FILL_SCROLL_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define FFSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define FFSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ffse_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
`default_nettype none

package ffse_pkg;

  localparam int MAX_DIM   = 2048;
  localparam int MEM_WORDS = 1048576;
  localparam int DIM_W     = 12;
  localparam int PIX_W     = 32;
  localparam int ADDR_W    = 2 * DIM_W;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_FILL   = 2'd2,
    ACT_SCROLL = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_PITCH  = 2'd3
  } cfg_idx_e;

  // Ways the datapath can set up its rectangle walker.
  typedef enum logic [2:0] {
    INIT_NONE,
    INIT_FILL,
    INIT_FULL,
    INIT_COPY,
    INIT_TAIL
  } walk_init_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_DISPATCH,
    S_RD_DATA,
    S_FILL,
    S_COPY_RD,
    S_COPY_WR,
    S_TAIL_START,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       mul;
    logic       clr_wr;
    logic       rd_pix;
    logic       wr_pix;
    logic       cap_pix;
    logic       res_set;
    logic       res_ok;
    walk_init_e walk_init;
    logic       fill_wr;
    logic       copy_rd;
    logic       copy_wr;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    enabled;
    action_e action;
    logic    in_surf;
    logic    fill_empty;
    logic    h_zero;
    logic    w_zero;
    logic    p_zero;
    logic    n_zero;
    logic    full;
    logic    last_col;
    logic    last_row;
    logic    clr_last;
  } dp_status_t;

  // Dimension registers keep the low twelve bits and saturate at the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ffse_ram.sv */
// Generic single-port RAM with registered read data.
`default_nettype none

module ffse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read of the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

/* rtl/ffse_dp.sv */
// Datapath: configuration, command latch, address math, walker and pixel store.
`default_nettype none

module ffse_dp
  import ffse_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_wdata_i,
  input  wire logic [1:0]           action_i,
  input  wire logic [DIM_W-1:0]     pos_x_i,
  input  wire logic [DIM_W-1:0]     pos_y_i,
  input  wire logic [DIM_W-1:0]     rect_width_i,
  input  wire logic [DIM_W-1:0]     rect_height_i,
  input  wire logic [DIM_W-1:0]     scroll_rows_i,
  input  wire logic [PIX_W-1:0]     color_i,
  input  wire dp_cmd_t              cmd_i,
  output dp_status_t                status_o,
  output logic      [PIX_W-1:0]     pixel_value_o,
  output logic                      in_bounds_o
);

  // Configuration registers.
  logic             enable_q;
  logic [DIM_W-1:0] width_q, height_q, pitch_q;

  // Latched command word.
  action_e          act_q;
  logic [DIM_W-1:0] x_q, y_q, w_q, h_q, n_q;
  logic [PIX_W-1:0] color_q;

  // Address product and walker state.
  logic [ADDR_W-1:0] mul_q;
  logic [ADDR_W-1:0] row_base_q, col_addr_q, src_row_q, src_addr_q;
  logic [DIM_W-1:0]  col_q, row_q, col_lim_q, row_lim_q;
  logic [MEM_AW-1:0] clr_q;

  // Result registers.
  logic [PIX_W-1:0] pix_q;
  logic             ok_q;

  // Store port.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;

  logic [DIM_W-1:0] rem_w, rem_h, clip_w, clip_h, keep;
  logic [DIM_W-1:0] mul_y, mul_x;
  logic             in_surf, full, last_col, last_row;

  function automatic logic in_store(input logic [ADDR_W-1:0] a);
    return {1'b0, a} < (ADDR_W+1)'(MEM_WORDS);
  endfunction

  // Configuration writes; dimensions saturate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      pitch_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE: enable_q <= cfg_wdata_i[0];
        CFG_WIDTH:  width_q  <= clamp_dim(cfg_wdata_i);
        CFG_HEIGHT: height_q <= clamp_dim(cfg_wdata_i);
        CFG_PITCH:  pitch_q  <= clamp_dim(cfg_wdata_i);
      endcase
    end
  end

  // Command latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_e'(action_i);
      x_q     <= pos_x_i;
      y_q     <= pos_y_i;
      w_q     <= rect_width_i;
      h_q     <= rect_height_i;
      n_q     <= scroll_rows_i;
      color_q <= color_i;
    end
  end

  // Clipping and scroll decisions from the latched word.
  always_comb begin
    in_surf = (x_q < width_q) && (y_q < height_q);
    rem_w   = width_q - x_q;
    rem_h   = height_q - y_q;
    clip_w  = (w_q > rem_w) ? rem_w : w_q;
    clip_h  = (h_q > rem_h) ? rem_h : h_q;
    full    = n_q >= height_q;
    keep    = height_q - n_q;
  end

  // Start address: row times pitch plus column. A scroll starts its source at row N,
  // or at the origin when the whole surface is cleared.
  always_comb begin
    if (act_q == ACT_SCROLL) begin
      mul_y = full ? '0 : n_q;
      mul_x = '0;
    end else begin
      mul_y = y_q;
      mul_x = x_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      mul_q <= ADDR_W'(mul_y) * ADDR_W'(pitch_q) + ADDR_W'(mul_x);
    end
  end

  assign last_col = col_q == (col_lim_q - DIM_W'(1));
  assign last_row = row_q == (row_lim_q - DIM_W'(1));

  // Rectangle walker: one pixel per step, rows advance by the pitch.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.walk_init)
      INIT_FILL: begin
        row_base_q <= mul_q;
        col_addr_q <= mul_q;
        col_lim_q  <= clip_w;
        row_lim_q  <= clip_h;
        col_q      <= '0;
        row_q      <= '0;
      end
      INIT_FULL: begin
        row_base_q <= mul_q;
        col_addr_q <= mul_q;
        col_lim_q  <= width_q;
        row_lim_q  <= height_q;
        col_q      <= '0;
        row_q      <= '0;
      end
      INIT_COPY: begin
        row_base_q <= '0;
        col_addr_q <= '0;
        src_row_q  <= mul_q;
        src_addr_q <= mul_q;
        col_lim_q  <= pitch_q;
        row_lim_q  <= keep;
        col_q      <= '0;
        row_q      <= '0;
      end
      INIT_TAIL: begin
        col_addr_q <= row_base_q;
        col_lim_q  <= width_q;
        row_lim_q  <= n_q;
        col_q      <= '0;
        row_q      <= '0;
      end
      INIT_NONE: begin
        if (cmd_i.fill_wr || cmd_i.copy_wr) begin
          if (last_col) begin
            col_q      <= '0;
            row_q      <= row_q + DIM_W'(1);
            row_base_q <= row_base_q + ADDR_W'(pitch_q);
            col_addr_q <= row_base_q + ADDR_W'(pitch_q);
            src_row_q  <= src_row_q + ADDR_W'(pitch_q);
            src_addr_q <= src_row_q + ADDR_W'(pitch_q);
          end else begin
            col_q      <= col_q + DIM_W'(1);
            col_addr_q <= col_addr_q + ADDR_W'(1);
            src_addr_q <= src_addr_q + ADDR_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Clearing pass address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + MEM_AW'(1);
    end
  end

  // Store port selection; addresses outside the store are dropped.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = mul_q;
    ram_wdata = color_q;
    priority if (cmd_i.clr_wr) begin
      ram_we    = 1'b1;
      ram_addr  = ADDR_W'(clr_q);
      ram_wdata = '0;
    end else if (cmd_i.wr_pix) begin
      ram_we    = in_store(mul_q);
    end else if (cmd_i.rd_pix) begin
      ram_addr  = mul_q;
    end else if (cmd_i.fill_wr) begin
      ram_addr  = col_addr_q;
      ram_we    = in_store(col_addr_q);
    end else if (cmd_i.copy_rd) begin
      ram_addr  = src_addr_q;
    end else if (cmd_i.copy_wr) begin
      ram_addr  = col_addr_q;
      ram_wdata = ram_rdata;
      ram_we    = in_store(col_addr_q) && in_store(src_addr_q);
    end
  end

  ffse_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MEM_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr[MEM_AW-1:0]),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      pix_q <= '0;
      ok_q  <= cmd_i.res_ok;
    end else if (cmd_i.cap_pix) begin
      pix_q <= in_store(mul_q) ? ram_rdata : '0;
    end
  end

  assign pixel_value_o = pix_q;
  assign in_bounds_o   = ok_q;

  always_comb begin
    status_o.enabled    = enable_q;
    status_o.action     = act_q;
    status_o.in_surf    = in_surf;
    status_o.fill_empty = !in_surf || (clip_w == '0) || (clip_h == '0);
    status_o.h_zero     = height_q == '0;
    status_o.w_zero     = width_q == '0;
    status_o.p_zero     = pitch_q == '0;
    status_o.n_zero     = n_q == '0;
    status_o.full       = full;
    status_o.last_col   = last_col;
    status_o.last_row   = last_row;
    status_o.clr_last   = clr_q == MEM_AW'(MEM_WORDS - 1);
  end

endmodule

`default_nettype wire

/* rtl/ffse_ctrl.sv */
// Controller: sequences the clearing pass and every command through the datapath.
`default_nettype none

module ffse_ctrl
  import ffse_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o,
  output logic            busy,
  output logic            done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DISPATCH;
      end
      S_DISPATCH: begin
        cmd_o.res_set = 1'b1;
        state_d       = S_DONE;
        if (status_i.enabled) begin
          unique case (status_i.action)
            ACT_READ: begin
              if (status_i.in_surf) begin
                cmd_o.res_ok = 1'b1;
                cmd_o.rd_pix = 1'b1;
                state_d      = S_RD_DATA;
              end
            end
            ACT_WRITE: begin
              if (status_i.in_surf) begin
                cmd_o.res_ok = 1'b1;
                cmd_o.wr_pix = 1'b1;
              end
            end
            ACT_FILL: begin
              if (!status_i.fill_empty) begin
                cmd_o.res_ok    = 1'b1;
                cmd_o.walk_init = INIT_FILL;
                state_d         = S_FILL;
              end
            end
            ACT_SCROLL: begin
              if (!status_i.h_zero) begin
                cmd_o.res_ok = 1'b1;
                if (status_i.full) begin
                  // Scrolling past the bottom clears the whole surface.
                  if (!status_i.w_zero) begin
                    cmd_o.walk_init = INIT_FULL;
                    state_d         = S_FILL;
                  end
                end else begin
                  cmd_o.walk_init = INIT_COPY;
                  state_d = status_i.p_zero ? S_TAIL_START : S_COPY_RD;
                end
              end
            end
          endcase
        end
      end
      S_RD_DATA: begin
        cmd_o.cap_pix = 1'b1;
        state_d       = S_DONE;
      end
      S_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (status_i.last_col && status_i.last_row) begin
          state_d = S_DONE;
        end
      end
      S_COPY_RD: begin
        cmd_o.copy_rd = 1'b1;
        state_d       = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        state_d = (status_i.last_col && status_i.last_row) ? S_TAIL_START : S_COPY_RD;
      end
      S_TAIL_START: begin
        // Paint the vacated bottom rows, if there are any.
        if (status_i.w_zero || status_i.n_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.walk_init = INIT_TAIL;
          state_d         = S_FILL;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;

endmodule

`default_nettype wire

/* rtl/framebuffer_fill_scroll_engine_top.sv */
// Top level of the framebuffer fill and scroll engine.
// Each command word is latched, its start address worked out, then dispatched: a read
// captures a pixel, a write stores one, a fill writes each clipped pixel, and a scroll
// reads and writes each pitch pixel of each kept row, then paints the vacated rows, or
// paints the whole surface. One command in flight; the next word is taken in the cycle
// after a result at the earliest, the receiver cannot stall. Reset clears the store.
`default_nettype none

module framebuffer_fill_scroll_engine_top
  import ffse_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_wdata_i,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           action_i,
  input  wire logic [DIM_W-1:0]     pos_x_i,
  input  wire logic [DIM_W-1:0]     pos_y_i,
  input  wire logic [DIM_W-1:0]     rect_width_i,
  input  wire logic [DIM_W-1:0]     rect_height_i,
  input  wire logic [DIM_W-1:0]     scroll_rows_i,
  input  wire logic [PIX_W-1:0]     color_i,
  output logic                      done_o,
  output logic      [PIX_W-1:0]     pixel_value_o,
  output logic                      in_bounds_o
);

  // After reset busy stays high while the store is cleared.
  dp_cmd_t    cmd;
  dp_status_t status;

  ffse_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  ffse_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .action_i      (action_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .scroll_rows_i (scroll_rows_i),
    .color_i       (color_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .pixel_value_o (pixel_value_o),
    .in_bounds_o   (in_bounds_o)
  );

endmodule

`default_nettype wire

/* rtl/ffse_checker.sv */
// Port-level checker for the framebuffer engine and its bind to the top level.
`default_nettype none

`include "framebuffer_fill_scroll_engine_top_assert.svh"

module ffse_checker
  import ffse_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done_o,
  input wire logic [PIX_W-1:0] pixel_value_o,
  input wire logic             in_bounds_o
);

  // An accepted command word keeps the engine busy in the next cycle.
  `FFSE_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept without busy")

  // A result word only appears while a command is in flight.
  `FFSE_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy, "result while idle")

  // The result strobe lasts one cycle and the engine is then free again.
  `FFSE_ASSERT_NXT(a_done_once, clk_i, rst_ni, done_o, !done_o && !busy, "result strobe held")

  // A failed command never reports pixel data.
  `FFSE_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, done_o && !in_bounds_o, pixel_value_o == '0,
                   "pixel on failed command")

endmodule

bind framebuffer_fill_scroll_engine_top ffse_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .pixel_value_o (pixel_value_o),
  .in_bounds_o   (in_bounds_o)
);

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the framebuffer fill and scroll engine.
`default_nettype none

module testbench;
  import ffse_pkg::*;

  localparam int WATCHDOG_LIMIT = 5_000_000;
  localparam int MAX_REPORTS    = 10;
  localparam int COPY_BUDGET    = 4096;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             ok;
  } fb_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DIM_W-1:0]     cfg_wdata_i;
  logic                 start;
  logic                 busy;
  logic [1:0]           action_i;
  logic [DIM_W-1:0]     pos_x_i;
  logic [DIM_W-1:0]     pos_y_i;
  logic [DIM_W-1:0]     rect_width_i;
  logic [DIM_W-1:0]     rect_height_i;
  logic [DIM_W-1:0]     scroll_rows_i;
  logic [PIX_W-1:0]     color_i;
  logic                 done_o;
  logic [PIX_W-1:0]     pixel_value_o;
  logic                 in_bounds_o;

  framebuffer_fill_scroll_engine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .scroll_rows_i (scroll_rows_i),
    .color_i       (color_i),
    .done_o        (done_o),
    .pixel_value_o (pixel_value_o),
    .in_bounds_o   (in_bounds_o)
  );

  // Shadow copy of the pixel store and the surface registers.
  bit [PIX_W-1:0] shadow_mem [MEM_WORDS];
  bit             shadow_en;
  longint         shadow_w;
  longint         shadow_h;
  longint         shadow_p;

  fb_result_t pending_results[$];
  int         mismatch_count;
  int         idle_pct;
  int         quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Dimension registers keep twelve bits and saturate at the maximum.
  function automatic longint sat_dim(logic [DIM_W-1:0] v);
    return (longint'(v) > MAX_DIM) ? longint'(MAX_DIM) : longint'(v);
  endfunction

  function automatic longint pix_addr(longint x, longint y);
    return y * shadow_p + x;
  endfunction

  function automatic bit [PIX_W-1:0] mem_load(longint a);
    return (a < MEM_WORDS) ? shadow_mem[a] : '0;
  endfunction

  function automatic void mem_store(longint a, bit [PIX_W-1:0] v);
    if (a < MEM_WORDS) begin
      shadow_mem[a] = v;
    end
  endfunction

  // Paint a rectangle clipped to the surface; returns whether anything was left.
  function automatic bit paint_clipped(longint x, longint y, longint w, longint h,
                                       bit [PIX_W-1:0] c);
    longint cw;
    longint ch;
    cw = w;
    ch = h;
    if (x >= shadow_w || y >= shadow_h) begin
      return 1'b0;
    end
    if (cw > shadow_w - x) cw = shadow_w - x;
    if (ch > shadow_h - y) ch = shadow_h - y;
    if (cw == 0 || ch == 0) begin
      return 1'b0;
    end
    for (longint r = 0; r < ch; r++) begin
      for (longint col = 0; col < cw; col++) begin
        mem_store(pix_addr(x + col, y + r), c);
      end
    end
    return 1'b1;
  endfunction

  // Copy whole pitch rows upward, then paint the vacated rows; paint all if n >= height.
  function automatic void scroll_shadow(longint n, bit [PIX_W-1:0] c);
    longint keep;
    longint dst;
    longint src;
    bit     unused;
    if (n >= shadow_h) begin
      unused = paint_clipped(0, 0, shadow_w, shadow_h, c);
    end else begin
      keep = shadow_h - n;
      for (longint y = 0; y < keep; y++) begin
        for (longint i = 0; i < shadow_p; i++) begin
          dst = pix_addr(i, y);
          src = pix_addr(i, y + n);
          if (dst < MEM_WORDS && src < MEM_WORDS) begin
            shadow_mem[dst] = shadow_mem[src];
          end
        end
      end
      unused = paint_clipped(0, keep, shadow_w, n, c);
    end
  endfunction

  // Work out the result word of one command and update the shadow state.
  function automatic fb_result_t predict_cmd(action_e act, logic [DIM_W-1:0] x,
                                             logic [DIM_W-1:0] y, logic [DIM_W-1:0] rw,
                                             logic [DIM_W-1:0] rh, logic [DIM_W-1:0] sr,
                                             logic [PIX_W-1:0] c);
    fb_result_t res;
    bit         in_surf;
    res = '0;
    if (shadow_en) begin
      in_surf = longint'(x) < shadow_w && longint'(y) < shadow_h;
      case (act)
        ACT_READ: begin
          if (in_surf) begin
            res.pixel = mem_load(pix_addr(longint'(x), longint'(y)));
            res.ok    = 1'b1;
          end
        end
        ACT_WRITE: begin
          if (in_surf) begin
            mem_store(pix_addr(longint'(x), longint'(y)), c);
            res.ok = 1'b1;
          end
        end
        ACT_FILL: begin
          res.ok = paint_clipped(longint'(x), longint'(y), longint'(rw), longint'(rh), c);
        end
        default: begin
          scroll_shadow(longint'(sr), c);
          res.ok = shadow_h != 0;
        end
      endcase
    end
    return res;
  endfunction

  // Wait until every expected word has come back and the block is free.
  task automatic wait_idle();
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  // Write all four surface registers while the block is idle.
  task automatic set_surface(logic [DIM_W-1:0] en_word, logic [DIM_W-1:0] w,
                             logic [DIM_W-1:0] h, logic [DIM_W-1:0] p);
    logic [DIM_W-1:0] vals [4];
    vals[CFG_ENABLE] = en_word;
    vals[CFG_WIDTH]  = w;
    vals[CFG_HEIGHT] = h;
    vals[CFG_PITCH]  = p;
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(i);
      cfg_wdata_i <= vals[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_en = en_word[0];
    shadow_w  = sat_dim(w);
    shadow_h  = sat_dim(h);
    shadow_p  = sat_dim(p);
  endtask

  // Send one command word, with a random gap in front of it.
  task automatic send_cmd(action_e act, logic [DIM_W-1:0] x, logic [DIM_W-1:0] y,
                          logic [DIM_W-1:0] rw, logic [DIM_W-1:0] rh,
                          logic [DIM_W-1:0] sr, logic [PIX_W-1:0] c);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) @(negedge clk_i);
    action_i      <= act;
    pos_x_i       <= x;
    pos_y_i       <= y;
    rect_width_i  <= rw;
    rect_height_i <= rh;
    scroll_rows_i <= sr;
    color_i       <= c;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(predict_cmd(act, x, y, rw, rh, sr, c));
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Random command word: mostly near the surface, sometimes anywhere.
  task automatic send_random();
    action_e          act;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] rw;
    logic [DIM_W-1:0] rh;
    logic [DIM_W-1:0] sr;
    longint           max_keep;
    act = action_e'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 80) begin
      x  = DIM_W'($urandom_range(0, int'(shadow_w) + 1));
      y  = DIM_W'($urandom_range(0, int'(shadow_h) + 1));
      rw = DIM_W'($urandom_range(0, int'(shadow_w) + 2));
      rh = DIM_W'($urandom_range(0, int'(shadow_h) + 2));
      sr = DIM_W'($urandom_range(0, int'(shadow_h) + 1));
    end else begin
      x  = DIM_W'($urandom());
      y  = DIM_W'($urandom());
      rw = DIM_W'($urandom());
      rh = DIM_W'($urandom());
      sr = DIM_W'($urandom());
    end
    // Keep the rows copied by a scroll within a bounded number of cycles.
    max_keep = (shadow_p == 0) ? shadow_h : COPY_BUDGET / shadow_p;
    if (shadow_h > max_keep && longint'(sr) < shadow_h - max_keep) begin
      sr = DIM_W'(shadow_h - max_keep);
    end
    send_cmd(act, x, y, rw, rh, sr, $urandom());
  endtask

  // Commands before the surface is enabled, and with enable low but sizes saturated.
  task automatic test_disabled();
    send_cmd(ACT_WRITE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    set_surface(12'hFFE, 12'hFFF, 12'hFFF, 12'hFFF);
    send_cmd(ACT_FILL, 0, 0, 5, 5, 0, 32'h1234_5678);
    send_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
  endtask

  // Single pixels at the surface corners, at the store edge and past it.
  task automatic test_full_surface_points();
    set_surface(12'h001, 12'hFFF, 12'hFFF, 12'hFFF);
    send_cmd(ACT_WRITE, 0, 0, 0, 0, 0, 32'hA5A5_5A5A);
    send_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_WRITE, 2047, 0, 0, 0, 0, 32'h0F0F_F0F0);
    send_cmd(ACT_READ, 2047, 0, 0, 0, 0, 0);
    send_cmd(ACT_WRITE, 2047, 511, 0, 0, 0, 32'hDEAD_BEEF);
    send_cmd(ACT_READ, 2047, 511, 0, 0, 0, 0);
    send_cmd(ACT_WRITE, 0, 512, 0, 0, 0, 32'hCAFE_F00D);
    send_cmd(ACT_READ, 0, 512, 0, 0, 0, 0);
    send_cmd(ACT_READ, 2048, 0, 0, 0, 0, 0);
    send_cmd(ACT_READ, 4095, 4095, 0, 0, 0, 0);
  endtask

  // Fills clipped at the far corner, across the store edge, and empty ones.
  task automatic test_full_surface_fill();
    send_cmd(ACT_FILL, 2045, 2045, 4095, 4095, 0, 32'h1111_1111);
    send_cmd(ACT_FILL, 2044, 510, 10, 4, 0, 32'h2222_2222);
    send_cmd(ACT_READ, 2047, 511, 0, 0, 0, 0);
    send_cmd(ACT_FILL, 3, 3, 0, 7, 0, 32'h3333_3333);
    send_cmd(ACT_FILL, 2048, 0, 4, 4, 0, 32'h4444_4444);
  endtask

  // Scroll by zero, by part of the height, and by more than the height.
  task automatic test_scroll();
    set_surface(12'h001, 6, 5, 8);
    send_cmd(ACT_FILL, 0, 0, 6, 5, 0, 32'h0000_00C1);
    send_cmd(ACT_WRITE, 2, 4, 0, 0, 0, 32'h0000_00C2);
    send_cmd(ACT_SCROLL, 0, 0, 0, 0, 0, 32'h0000_00C9);
    send_cmd(ACT_SCROLL, 0, 0, 0, 0, 2, 32'h0000_00C3);
    send_cmd(ACT_READ, 2, 2, 0, 0, 0, 0);
    send_cmd(ACT_READ, 2, 4, 0, 0, 0, 0);
    send_cmd(ACT_SCROLL, 0, 0, 0, 0, 4095, 32'h0000_00C4);
    send_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
  endtask

  // A surface with no rows: scroll reports nothing and reads give zero.
  task automatic test_empty_surface();
    set_surface(12'h001, 6, 0, 8);
    send_cmd(ACT_SCROLL, 0, 0, 0, 0, 1, 32'h5555_5555);
    send_cmd(ACT_READ, 0, 0, 0, 0, 0, 0);
  endtask

  // Random commands over several surface shapes and idle patterns.
  task automatic test_random();
    int idle_modes [3];
    idle_modes[0] = 0;
    idle_modes[1] = 73;
    idle_modes[2] = 7;
    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = idle_modes[ph % 3];
      case (ph)
        1: set_surface(12'hFFF, 12'hA00, 2, 12'hFFF);
        2: set_surface(12'h001, 2, 12'hFFF, 2);
        3: set_surface(12'h001, 20, 10, 7);
        4: set_surface(12'h001, 5, 6, 0);
        5: set_surface(12'h002, 8, 8, 8);
        6: set_surface(12'h001, 4, 600, 2048);
        7: set_surface(12'h001, 0, 9, 3);
        default: begin
          shadow_w = $urandom_range(1, 24);
          set_surface(12'h001, DIM_W'(shadow_w), DIM_W'($urandom_range(1, 24)),
                      DIM_W'(shadow_w + $urandom_range(0, 8)));
        end
      endcase
      for (int k = 0; k < 45; k++) begin
        // Now and then hold off until the block has drained.
        if (k == 20 || $urandom_range(0, 99) < 3) wait_idle();
        send_random();
      end
    end
  endtask

  task automatic finish_run();
    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  endtask

  // Compare each result word with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    fb_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result with none expected: pixel %h ok %b",
                   $realtime, pixel_value_o, in_bounds_o);
        end
      end else begin
        want = pending_results.pop_front();
        if (pixel_value_o !== want.pixel || in_bounds_o !== want.ok) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch: expected pixel %h ok %b, got pixel %h ok %b",
                     $realtime, want.pixel, want.ok, pixel_value_o, in_bounds_o);
          end
        end
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_ENABLE;
    cfg_wdata_i    = '0;
    start          = 1'b0;
    action_i       = ACT_READ;
    pos_x_i        = '0;
    pos_y_i        = '0;
    rect_width_i   = '0;
    rect_height_i  = '0;
    scroll_rows_i  = '0;
    color_i        = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    idle_pct       = 0;
    shadow_en      = 1'b0;
    shadow_w       = 0;
    shadow_h       = 0;
    shadow_p       = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_disabled();
    test_full_surface_points();
    test_full_surface_fill();
    test_scroll();
    test_empty_surface();
    test_random();
    finish_run();
  end

endmodule

`default_nettype wire
